// File: rtl/core/krl_pkg.sv
package krl_pkg;

  // Default geometry
  localparam int unsigned DefDepth   = 16;
  localparam int unsigned DefKeyBits = 64;

  // Fixed word field widths
  localparam int unsigned KeyW   = 64;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    ActInsert = 2'd0,
    ActMark   = 2'd1,
    ActDelete = 2'd2,
    ActFind   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StInsert,
    StScan,
    StShift,
    StDone
  } state_e;

  typedef struct packed {
    action_e           action;
    logic [KeyW-1:0]   key;
    logic              read_flag;
  } krl_in_t;

  typedef struct packed {
    logic              ok;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
  } krl_out_t;

endpackage

// File: rtl/core/krl_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module krl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/keyed_record_list_core.sv
// Ordered list of up to DEPTH records (key + read flag) held in one RAM.
// Insert appends at the tail; its result goes through the StInsert and
// StDone states into the output register. Mark-read, delete and find walk
// the list from index 0 through the single RAM read port and one key
// comparator, one record per cycle. Find and mark-read stop the walk at
// the first hit; a miss searches every record. A delete that hits keeps
// walking to the tail, moving each later record down one slot, before its
// result goes to StDone. One word is worked on at a time: in_stall_o is
// high from acceptance until the result is loaded into the output
// register, so the next word can be taken in the cycle after that.
// A result waiting on out_stall_i does not block acceptance of the next word.
// Only the low KEY_BITS of a key are stored and compared. No clearing pass
// after reset: only entries below the fill count are ever read.
module keyed_record_list_core #(
  parameter int unsigned DEPTH    = krl_pkg::DefDepth,
  parameter int unsigned KEY_BITS = krl_pkg::DefKeyBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  krl_pkg::krl_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output krl_pkg::krl_out_t  out_data_o
);

  import krl_pkg::*;

  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned WordW = KEY_BITS + 1;  // {key, read flag}

  state_e state_q, state_d;

  // Control state
  logic [CntW-1:0] count_q, count_d;    // records held
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;  // next RAM read index
  logic            cmp_vld_q, cmp_vld_d;  // RAM read data belongs to a walk
  logic            out_valid_q, out_valid_d;

  // Payload state
  krl_in_t         item_q, item_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;  // index of the record in rdata
  logic            ok_q, ok_d;
  logic [PosW-1:0] pos_q, pos_d;
  krl_out_t        out_q, out_d;

  // RAM port signals
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [WordW-1:0] ram_rdata;

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] rkey;
  logic                in_acc;
  logic                out_free;
  logic                issue;
  logic                hit;
  logic                miss;
  logic                walk_end;
  logic                full;

  assign key_q    = item_q.key[KEY_BITS-1:0];
  assign rkey     = ram_rdata[WordW-1:1];
  assign in_acc   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q >= CntW'(DEPTH));

  // Walk: one read issued per cycle while below the fill count
  assign issue    = ((state_q == StScan) || (state_q == StShift)) && (rd_ptr_q < count_q);
  assign hit      = (state_q == StScan) && cmp_vld_q && (rkey == key_q);
  assign miss     = (state_q == StScan) && !hit && (rd_ptr_q == count_q);
  assign walk_end = (rd_ptr_q == count_q) && !cmp_vld_q;

  krl_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = (in_data_i.action == ActInsert) ? StInsert : StScan;
        end
      end
      StInsert: state_d = StDone;
      StScan: begin
        if (hit) begin
          state_d = (item_q.action == ActDelete) ? StShift : StDone;
        end else if (miss) begin
          state_d = StDone;
        end
      end
      StShift: begin
        if (walk_end) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    item_d      = item_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_vld_d   = issue;
    cmp_idx_d   = cmp_idx_q;
    ok_d        = ok_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = cmp_idx_q;
    ram_wdata   = {rkey, 1'b1};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (issue) begin
      rd_ptr_d  = rd_ptr_q + CntW'(1);
      cmp_idx_d = rd_ptr_q[IdxW-1:0];
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          item_d   = in_data_i;
          rd_ptr_d = '0;
        end
      end
      StInsert: begin
        if (!full) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[IdxW-1:0];
          ram_wdata = {key_q, item_q.read_flag};
          ok_d      = 1'b1;
          pos_d     = PosW'(count_q);
          count_d   = count_q + CntW'(1);
        end else begin
          ok_d  = 1'b0;
          pos_d = '0;
        end
      end
      StScan: begin
        if (hit) begin
          ok_d  = 1'b1;
          pos_d = PosW'(cmp_idx_q);
          // Mark-read rewrites the matched record with its flag set
          ram_we = (item_q.action == ActMark);
        end else if (miss) begin
          ok_d  = 1'b0;
          pos_d = '0;
        end
      end
      StShift: begin
        // Each later record moves down one slot
        if (cmp_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_q - IdxW'(1);
          ram_wdata = ram_rdata;
        end
        if (walk_end) begin
          count_d = count_q - CntW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.ok       = ok_q;
          out_d.position = pos_q;
          out_d.count    = CountW'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    cmp_idx_q <= cmp_idx_d;
    ok_q      <= ok_d;
    pos_q     <= pos_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/tb_keyed_record_list_core.sv
module tb_keyed_record_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  import krl_pkg::*;

  localparam int unsigned DEPTH    = DefDepth;
  localparam int unsigned KEY_BITS = DefKeyBits;

  // Only the low KEY_BITS of a key are stored and compared.
  localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} >> (KeyW - KEY_BITS);

  // Receiver hold-off length for the back-pressure test; the watchdog
  // limit sits well above it and above the slowest delete.
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned DrainTail  = 2 * DEPTH + 8;
  localparam int unsigned PoolSize   = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  krl_in_t   in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  krl_out_t  out_data_o;

  // Shadow copy of the record list, updated at each accepted input word.
  logic [KeyW-1:0] list_keys [DEPTH];
  logic            list_read [DEPTH];
  int unsigned     list_fill = 0;

  // Result words predicted but not yet seen at the output.
  krl_out_t pending_results [$];

  int unsigned fail_cnt      = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long receiver hold: the test bumps hold_req, the receiver process acks.
  int unsigned hold_req  = 0;
  int unsigned hold_ack  = 0;
  int unsigned hold_left = 0;

  // Keys reused across inserts and lookups so that searches actually hit.
  logic [KeyW-1:0] key_pool [PoolSize];

  keyed_record_list_core #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one action to the shadow list and returns the result word.
  // Lookups act on the lowest matching index; delete compacts the tail.
  function automatic krl_out_t apply_list_action(input krl_in_t w);
    krl_out_t        r;
    logic [KeyW-1:0] k;
    int              hit;
    int unsigned     i;
    r   = '0;
    k   = w.key & KeyMask;
    hit = -1;
    if (w.action == ActInsert) begin
      // full list: nothing stored, ok and position stay zero
      if (list_fill < DEPTH) begin
        list_keys[list_fill] = k;
        list_read[list_fill] = w.read_flag;
        r.ok       = 1'b1;
        r.position = PosW'(list_fill);
        list_fill++;
      end
    end else begin
      for (i = 0; i < list_fill; i++) begin
        if (hit < 0 && list_keys[i] == k) hit = int'(i);
      end
      if (hit >= 0) begin
        r.ok       = 1'b1;
        r.position = PosW'(hit);
        if (w.action == ActMark) begin
          list_read[hit] = 1'b1;
        end else if (w.action == ActDelete) begin
          for (i = unsigned'(hit); i + 1 < list_fill; i++) begin
            list_keys[i] = list_keys[i + 1];
            list_read[i] = list_read[i + 1];
          end
          list_fill--;
        end
      end
    end
    r.count = CountW'(list_fill);
    return r;
  endfunction

  function automatic krl_in_t make_word(input action_e act, input logic [KeyW-1:0] k,
                                        input logic flag);
    krl_in_t w;
    w.action    = act;
    w.key       = k;
    w.read_flag = flag;
    return w;
  endfunction

  // Offers one word, holds it until accepted, then predicts its result.
  // Called and returns on a rising edge. Valid stays high into the next
  // call unless a random gap is taken here.
  task automatic send_word(input krl_in_t w);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_list_action(w));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender pause: stop offering and wait until every result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    @(posedge clk_i);
  endtask

  // Lookups and delete on an empty list, then the basic hit paths with
  // extreme keys and a duplicate.
  task automatic test_empty_and_duplicates();
    send_word(make_word(ActFind,   '0, 1'b0));
    send_word(make_word(ActMark,   '0, 1'b1));
    send_word(make_word(ActDelete, {KeyW{1'b1}}, 1'b0));
    send_word(make_word(ActInsert, '0, 1'b0));
    send_word(make_word(ActInsert, {KeyW{1'b1}}, 1'b1));
    send_word(make_word(ActInsert, '0, 1'b1));            // duplicate key
    send_word(make_word(ActFind,   '0, 1'b0));            // lowest match wins
    send_word(make_word(ActMark,   {KeyW{1'b1}}, 1'b0));
    send_word(make_word(ActDelete, '0, 1'b1));            // removes head only
    send_word(make_word(ActFind,   '0, 1'b0));            // duplicate moved down
  endtask

  // Fills the list to DEPTH, overflows it, then hits both ends.
  task automatic test_full_list();
    logic [KeyW-1:0] k;
    k = 64'h0123_4567_89AB_CDEF;
    while (list_fill < DEPTH) begin
      k = {k[KeyW-5:0], k[KeyW-1:KeyW-4]} ^ 64'h8000_0000_0000_0001;
      send_word(make_word(ActInsert, k, k[0]));
    end
    send_word(make_word(ActInsert, 64'hDEAD_BEEF_0000_0001, 1'b1));   // full
    send_word(make_word(ActFind,   list_keys[DEPTH-1], 1'b0));         // tail index
    send_word(make_word(ActDelete, list_keys[DEPTH-1], 1'b0));
    send_word(make_word(ActDelete, list_keys[0], 1'b1));
    send_word(make_word(ActFind,   64'h5555_5555_5555_5555, 1'b0));    // absent
  endtask

  // Receiver starts a long hold-off while the sender keeps offering,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    int unsigned i;
    action_e     act;
    hold_req <= hold_req + 1;
    for (i = 0; i < 12; i++) begin
      if (i[0]) begin
        act = ActFind;
      end else begin
        act = ActInsert;
      end
      send_word(make_word(act, key_pool[$urandom_range(0, PoolSize - 1)],
                          1'($urandom_range(0, 1))));
    end
  endtask

  // Random traffic, mostly on pooled keys so lookups hit. The insert share
  // drifts per block of words so the count sweeps between empty and full.
  task automatic test_random_ops(input int unsigned n_items);
    int unsigned     i;
    int unsigned     ins_pct;
    int unsigned     pick;
    action_e         act;
    logic [KeyW-1:0] k;
    ins_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        ins_pct = $urandom_range(15, 85);
        key_pool[$urandom_range(0, PoolSize - 1)] = {$urandom, $urandom};
        key_pool[$urandom_range(0, PoolSize - 1)] = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) begin
        act = ActInsert;
      end else begin
        case ($urandom_range(0, 2))
          0:       act = ActMark;
          1:       act = ActDelete;
          default: act = ActFind;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        k = key_pool[$urandom_range(0, PoolSize - 1)];
      end else if (pick < 87) begin
        // near miss: one bit off a known key
        k = key_pool[$urandom_range(0, PoolSize - 1)] ^ (64'd1 << $urandom_range(0, KeyW - 1));
      end else begin
        k = {$urandom, $urandom};
      end
      send_word(make_word(act, k, 1'($urandom_range(0, 1))));
    end
  endtask

  // Receiver: random stall, or a long hold when the test asks for one.
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldLen;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result check: each accepted output word against the oldest prediction.
  always @(posedge clk_i) begin
    krl_out_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: ok=%0d position=%0d count=%0d",
               out_data_o.ok, out_data_o.position, out_data_o.count);
        fail_cnt++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data_o.ok !== exp_w.ok) begin
          $error("ok: expected %0d, got %0d", exp_w.ok, out_data_o.ok);
          fail_cnt++;
        end
        if (out_data_o.position !== exp_w.position) begin
          $error("position: expected %0d, got %0d", exp_w.position, out_data_o.position);
          fail_cnt++;
        end
        if (out_data_o.count !== exp_w.count) begin
          $error("count: expected %0d, got %0d", exp_w.count, out_data_o.count);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("[keyed_record_list_core] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    for (i = 0; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver heavily
    set_idling(12, 74);
    test_empty_and_duplicates();
    test_full_list();
    test_random_ops(290);
    test_output_backpressure();
    wait_drained();

    // sender idles heavily, receiver lightly
    set_idling(74, 12);
    test_random_ops(290);

    // back-to-back on both sides
    set_idling(0, 0);
    test_random_ops(290);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("[keyed_record_list_core] OK");
    end else begin
      $display("[keyed_record_list_core] ERROR");
    end
    $finish;
  end

endmodule
